// ----- design/utfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfd_pkg
// Types and constants shared by the UTF-8 byte decoder modules.
// ----------------------------------------------------------------------------
package utfd_pkg;

	localparam int CpWidth = 21;

	typedef enum logic [2:0] {
		ST_START  = 3'd0,
		ST_ACCEPT = 3'd1,
		ST_REJECT = 3'd2,
		ST_EXP1   = 3'd3,
		ST_EXP2   = 3'd4,
		ST_EXP3   = 3'd5
	} utfd_state_t;

	typedef enum logic {
		CMD_FEED  = 1'b0,
		CMD_RESET = 1'b1
	} utfd_cmd_t;

	localparam logic [CpWidth-1:0] REPLACEMENT_CP = 21'h00FFFD;

	localparam logic [7:0] LEAD_C0     = 8'hC0;
	localparam logic [7:0] LEAD_C1     = 8'hC1;
	localparam logic [7:0] MASK_TOP2   = 8'hC0;
	localparam logic [7:0] CONT_MARK   = 8'h80;
	localparam logic [7:0] MASK_TOP3   = 8'hE0;
	localparam logic [7:0] LEAD2_MARK  = 8'hC0;
	localparam logic [7:0] MASK_TOP4   = 8'hF0;
	localparam logic [7:0] LEAD3_MARK  = 8'hE0;
	localparam logic [7:0] MASK_TOP5   = 8'hF8;
	localparam logic [7:0] LEAD4_MARK  = 8'hF0;
	localparam logic [7:0] MASK_LEAD2  = 8'h1F;
	localparam logic [7:0] MASK_LEAD3  = 8'h0F;
	localparam logic [7:0] MASK_LEAD4  = 8'h07;
	localparam logic [7:0] MASK_CONT   = 8'h3F;

	typedef struct packed {
		logic       cmd;
		logic [7:0] byte_in;
	} utfd_in_t;

	typedef struct packed {
		logic [2:0]         parse_status;
		logic [CpWidth-1:0] code_point;
	} utfd_out_t;

	// decoder state held between items
	typedef struct packed {
		utfd_state_t        parse_state;
		logic [CpWidth-1:0] partial_code;
	} utfd_ctx_t;

endpackage

// ----- design/utfd_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfd_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface utfd_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- design/utfd_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfd_step
// Next-state logic of the decoder: one byte or reset command against the
// current context gives the new context and the result item.
// ----------------------------------------------------------------------------
module utfd_step
	import utfd_pkg::*;
(
	input  utfd_in_t  item,
	input  utfd_ctx_t ctx,
	output utfd_ctx_t ctx_next,
	output utfd_out_t result
);

	logic [7:0]         b;
	logic               is_cont;
	logic [CpWidth-1:0] cont_bits;
	utfd_ctx_t          nxt;

	assign b         = item.byte_in;
	assign is_cont   = (b & MASK_TOP2) == CONT_MARK;
	assign cont_bits = {{(CpWidth-6){1'b0}}, b[5:0] & MASK_CONT[5:0]};

	always_comb begin
		nxt = ctx;
		if (item.cmd == CMD_RESET) begin
			nxt.parse_state = ST_START;
		end else begin
			unique case (ctx.parse_state)
				ST_START, ST_ACCEPT, ST_REJECT: begin
					priority if (b == LEAD_C0 || b == LEAD_C1) begin
						nxt.parse_state = ST_REJECT;
					end else if (b[7] == 1'b0) begin
						nxt.partial_code = {{(CpWidth-8){1'b0}}, b};
						nxt.parse_state  = ST_ACCEPT;
					end else if (is_cont) begin
						// stray continuation byte is dropped
						nxt.parse_state = ST_START;
					end else if ((b & MASK_TOP3) == LEAD2_MARK) begin
						nxt.partial_code = {{(CpWidth-11){1'b0}}, b[4:0] & MASK_LEAD2[4:0],
							6'd0};
						nxt.parse_state  = ST_EXP1;
					end else if ((b & MASK_TOP4) == LEAD3_MARK) begin
						nxt.partial_code = {{(CpWidth-16){1'b0}}, b[3:0] & MASK_LEAD3[3:0],
							12'd0};
						nxt.parse_state  = ST_EXP2;
					end else if ((b & MASK_TOP5) == LEAD4_MARK) begin
						nxt.partial_code = {b[2:0] & MASK_LEAD4[2:0], 18'd0};
						nxt.parse_state  = ST_EXP3;
					end else begin
						nxt.parse_state = ST_REJECT;
					end
				end
				// bad continuation bytes still merge their low bits
				ST_EXP3: begin
					nxt.partial_code = ctx.partial_code | (cont_bits << 12);
					nxt.parse_state  = is_cont ? ST_EXP2 : ST_REJECT;
				end
				ST_EXP2: begin
					nxt.partial_code = ctx.partial_code | (cont_bits << 6);
					nxt.parse_state  = is_cont ? ST_EXP1 : ST_REJECT;
				end
				ST_EXP1: begin
					nxt.partial_code = ctx.partial_code | cont_bits;
					nxt.parse_state  = is_cont ? ST_ACCEPT : ST_REJECT;
				end
				default: begin
					nxt.parse_state = ST_REJECT;
				end
			endcase
		end
	end

	assign ctx_next = nxt;
	assign result   = {nxt.parse_state,
		(nxt.parse_state == ST_ACCEPT) ? nxt.partial_code : REPLACEMENT_CP};

endmodule

// ----- design/utf8_byte_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_byte_decoder
// Streaming UTF-8 decoder: one byte or reset command in, one status and
// code point out.
// ----------------------------------------------------------------------------
// Takes one item per cycle on byte_ch while result_ch is ready and returns
// exactly one result per item on result_ch. An input register feeds the
// next-state logic, whose output is captured in the result register while the
// parse state and partial code point update in the same edge; that state loop
// through a single register sets the rate of one byte per clock.
// The two stages stall together when a waiting result is not taken, and byte_ch still
// takes an item while a finished result waits if the input stage is empty.
// ----------------------------------------------------------------------------
module utf8_byte_decoder
	import utfd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	utfd_stream_if.sink   byte_ch,
	utfd_stream_if.source result_ch
);

	logic      valid_s1;
	utfd_in_t  item_s1;
	logic      valid_s2;
	utfd_out_t result_s2;
	utfd_ctx_t ctx_q;
	utfd_ctx_t ctx_next;
	utfd_out_t result_next;
	logic      advance;
	logic      take_in;

	// stage 2 can load when empty or when its result is being taken
	assign advance = !valid_s2 || result_ch.ready;
	assign take_in = byte_ch.valid && byte_ch.ready;

	assign byte_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= byte_ch.payload;
		end
	end

	utfd_step u_step (
		.item     (item_s1),
		.ctx      (ctx_q),
		.ctx_next (ctx_next),
		.result   (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2                <= 1'b0;
			ctx_q.parse_state       <= ST_START;
			ctx_q.partial_code      <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				ctx_q <= ctx_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= result_next;
		end
	end

	assign result_ch.valid   = valid_s2;
	assign result_ch.payload = result_s2;

endmodule

// ----- verif/utf8_byte_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_byte_decoder_tb
// Self-checking bench for the streaming UTF-8 byte decoder. A scoreboard
// tracks the parse state and partial code point for every accepted byte and
// compares each result transfer against the oldest pending prediction.
// Directed sequences cover ASCII at both ends, the lowest two-byte and top
// three- and four-byte code points, rejected leads, stray and bad continuation
// bytes, and reset commands. A random phase follows, mostly well-formed
// sequences with broken ones and noise mixed in. Both sides idle at random.
// ----------------------------------------------------------------------------
module utf8_byte_decoder_tb;
	import utfd_pkg::*;

	localparam int MaxGap      = 18;
	localparam int IdleLimit   = 2000;
	localparam int RandomItems = 1000;
	localparam int DrainCycles = 8;

	class codepoint_tracker;
		utfd_state_t        state;
		logic [CpWidth-1:0] partial;
		utfd_out_t          pending[$];
		int                 errors;

		function new();
			state   = ST_START;
			partial = '0;
			errors  = 0;
		endfunction

		// continuation payload is merged even when the marker bits are wrong
		function void merge_cont(logic [7:0] b, int shift, utfd_state_t next_state);
			logic [CpWidth-1:0] bits;
			bits    = CpWidth'(b & MASK_CONT);
			partial = partial | (bits << shift);
			state   = ((b & MASK_TOP2) == CONT_MARK) ? next_state : ST_REJECT;
		endfunction

		function void note_byte(utfd_in_t item);
			utfd_out_t want;
			logic [7:0] b;
			b = item.byte_in;
			if (item.cmd == CMD_RESET) begin
				state = ST_START;
			end else begin
				case (state)
					ST_START, ST_ACCEPT, ST_REJECT: begin
						if (b == LEAD_C0 || b == LEAD_C1) begin
							state = ST_REJECT;
						end else begin
							casez (b)
								8'b0???????: begin
									partial = CpWidth'(b);
									state   = ST_ACCEPT;
								end
								8'b10??????: state = ST_START;
								8'b110?????: begin
									partial = CpWidth'(b & MASK_LEAD2) << 6;
									state   = ST_EXP1;
								end
								8'b1110????: begin
									partial = CpWidth'(b & MASK_LEAD3) << 12;
									state   = ST_EXP2;
								end
								8'b11110???: begin
									partial = CpWidth'(b & MASK_LEAD4) << 18;
									state   = ST_EXP3;
								end
								default: state = ST_REJECT;
							endcase
						end
					end
					ST_EXP3: merge_cont(b, 12, ST_EXP2);
					ST_EXP2: merge_cont(b, 6, ST_EXP1);
					ST_EXP1: merge_cont(b, 0, ST_ACCEPT);
					default: state = ST_REJECT;
				endcase
			end
			want.parse_status = state;
			want.code_point   = (state == ST_ACCEPT) ? partial : REPLACEMENT_CP;
			pending.push_back(want);
		endfunction

		function void check_result(utfd_out_t got);
			utfd_out_t want;
			if (pending.size() == 0) begin
				$error("result with no byte pending: parse_status %0d code_point %h",
					got.parse_status, got.code_point);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.parse_status !== want.parse_status) begin
				$error("parse_status expected %0d actual %0d",
					want.parse_status, got.parse_status);
				errors++;
			end
			if (got.code_point !== want.code_point) begin
				$error("code_point expected %h actual %h", want.code_point, got.code_point);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	utfd_stream_if #(.payload_t(utfd_in_t))  byte_ch ();
	utfd_stream_if #(.payload_t(utfd_out_t)) result_ch ();

	utf8_byte_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch)
	);

	codepoint_tracker tracker = new();

	int sent_count;
	int received_count;
	int idle_cycles;
	bit sender_quiet;
	bit receiver_quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom)};
	endfunction

	// anything whose top two bits are not the continuation marker
	function automatic logic [7:0] bad_cont_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (b[7:6] == 2'b10)
			b[6] = 1'b1;
		return b;
	endfunction

	function automatic logic [7:0] lead_byte(input int len);
		case (len)
			1:       return {1'b0, 7'($urandom)};
			2:       return {3'b110, 5'($urandom)};
			3:       return {4'b1110, 4'($urandom)};
			default: return {5'b11110, 3'($urandom)};
		endcase
	endfunction

	// valid stays high across back-to-back transfers
	task automatic send_item(input utfd_cmd_t cmd, input logic [7:0] b);
		utfd_in_t item;
		int gap;
		item.cmd     = cmd;
		item.byte_in = b;
		gap = sender_quiet ? 0 : $urandom_range(0, MaxGap);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.payload <= item;
		do @(posedge clk); while (!byte_ch.ready);
		tracker.note_byte(item);
		sent_count++;
	endtask

	task automatic send_sequence(input int len);
		send_item(CMD_FEED, lead_byte(len));
		repeat (len - 1) send_item(CMD_FEED, cont_byte());
	endtask

	task automatic drain_results();
		byte_ch.valid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
	endtask

	// result side
	initial begin
		int gap;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (received_count % 64 == 0)
				receiver_quiet = ($urandom_range(0, 3) == 0);
			gap = receiver_quiet ? 0 : $urandom_range(0, MaxGap);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			tracker.check_result(result_ch.payload);
			received_count++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) ||
			(result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("utf8_byte_decoder_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		int kind;
		int len;
		int first_random;
		bit paused;
		arst_n          <= 1'b0;
		byte_ch.valid   <= 1'b0;
		byte_ch.payload <= '0;
		sender_quiet    = 1'b0;
		paused          = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_item(CMD_RESET, 8'hFF);
		send_item(CMD_FEED, 8'h00);
		// stray continuation while in accept
		send_item(CMD_FEED, 8'h80);
		send_item(CMD_FEED, 8'h7F);
		send_item(CMD_FEED, 8'hC2);
		send_item(CMD_FEED, 8'h80);
		send_item(CMD_FEED, 8'hEF);
		send_item(CMD_FEED, 8'hBF);
		send_item(CMD_FEED, 8'hBF);
		send_item(CMD_FEED, 8'hF7);
		send_item(CMD_FEED, 8'hBF);
		send_item(CMD_FEED, 8'hBF);
		send_item(CMD_FEED, 8'hBF);
		send_item(CMD_FEED, 8'hC0);
		send_item(CMD_FEED, 8'hC1);
		send_item(CMD_FEED, 8'hF8);
		send_item(CMD_FEED, 8'hFF);
		// stray continuation while in reject
		send_item(CMD_FEED, 8'hBF);
		// bad continuation is consumed
		send_item(CMD_FEED, 8'hC3);
		send_item(CMD_FEED, 8'h41);
		// reset in the middle of a sequence keeps the partial value
		send_item(CMD_FEED, 8'hE2);
		send_item(CMD_RESET, 8'h00);
		send_item(CMD_FEED, 8'h41);
		drain_results();

		first_random = sent_count;
		while (sent_count - first_random < RandomItems) begin
			if ((sent_count - first_random) % 100 < 4)
				sender_quiet = ($urandom_range(0, 3) == 0);
			if (!paused && sent_count - first_random >= RandomItems / 2) begin
				drain_results();
				paused = 1'b1;
			end
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				send_sequence($urandom_range(1, 4));
			end else if (kind < 82) begin
				// truncated sequence ended by a bad byte or a reset command
				len = $urandom_range(2, 4);
				send_item(CMD_FEED, lead_byte(len));
				repeat ($urandom_range(0, len - 2)) send_item(CMD_FEED, cont_byte());
				if ($urandom_range(0, 2) == 0)
					send_item(CMD_RESET, 8'($urandom));
				else
					send_item(CMD_FEED, bad_cont_byte());
			end else if (kind < 94) begin
				send_item(CMD_FEED, 8'($urandom));
			end else begin
				send_item(CMD_RESET, 8'($urandom));
			end
		end
		drain_results();
		repeat (DrainCycles) @(posedge clk);

		if (tracker.errors == 0 && tracker.pending.size() == 0) begin
			$display("utf8_byte_decoder_tb: clean");
		end else begin
			$display("utf8_byte_decoder_tb: errors");
		end
		$finish;
	end

endmodule
